// ----- rtl/sdh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdh_pkg
// Types, phase and status codes and helpers for the SD SPI host engine.
// ----------------------------------------------------------------------------
package sdh_pkg;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] lba;
		logic [7:0]  rx_byte;
		logic [7:0]  write_byte;
		logic        card_present;
		logic        bus_error;
	} sdh_in_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  tx_byte;
		logic        chip_select;
		logic        slow_clock;
		logic [3:0]  delay_ms;
		logic [7:0]  read_data;
		logic        read_valid;
		logic        write_taken;
		logic [3:0]  status;
		logic        done_res;
		logic [15:0] read_retry_count;
		logic [15:0] reinit_count;
	} sdh_out_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic [19:0] data;
	} sdh_cfg_t;

	localparam logic [2:0] CFG_RESP_POLL = 3'd0;
	localparam logic [2:0] CFG_IDLE_RETRY = 3'd1;
	localparam logic [2:0] CFG_OPC_RETRY = 3'd2;
	localparam logic [2:0] CFG_ILLEGAL = 3'd3;
	localparam logic [2:0] CFG_TOKEN_POLL = 3'd4;
	localparam logic [2:0] CFG_BUSY_POLL = 3'd5;
	localparam logic [2:0] CFG_READ_ATT = 3'd6;
	localparam logic [2:0] CFG_WAKE = 3'd7;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_BYTE = 2'd2;
	localparam logic [1:0] OP_WAIT = 2'd3;

	localparam logic [1:0] ACT_XFER = 2'd0;
	localparam logic [1:0] ACT_WAIT = 2'd1;
	localparam logic [1:0] ACT_DONE = 2'd2;

	localparam logic [4:0] P_IDLE = 5'd0;
	localparam logic [4:0] P_PWR = 5'd1;
	localparam logic [4:0] P_DESEL = 5'd2;
	localparam logic [4:0] P_CLOCKS = 5'd3;
	localparam logic [4:0] P_SETTLE = 5'd4;
	localparam logic [4:0] P_CMD = 5'd5;
	localparam logic [4:0] P_R1 = 5'd6;
	localparam logic [4:0] P_GAP = 5'd7;
	localparam logic [4:0] P_TRAIL = 5'd8;
	localparam logic [4:0] P_TOKEN = 5'd9;
	localparam logic [4:0] P_RDATA = 5'd10;
	localparam logic [4:0] P_RCRC = 5'd11;
	localparam logic [4:0] P_WPRE = 5'd12;
	localparam logic [4:0] P_WDATA = 5'd13;
	localparam logic [4:0] P_WCRC = 5'd14;
	localparam logic [4:0] P_WRESP = 5'd15;
	localparam logic [4:0] P_BUSY = 5'd16;

	localparam logic [2:0] R_CLOCKS = 3'd0;
	localparam logic [2:0] R_CMD0 = 3'd1;
	localparam logic [2:0] R_CMD8 = 3'd2;
	localparam logic [2:0] R_CMD55 = 3'd3;
	localparam logic [2:0] R_CMD41 = 3'd4;
	localparam logic [2:0] R_CMD58 = 3'd5;
	localparam logic [2:0] R_CMD16 = 3'd6;
	localparam logic [2:0] R_END = 3'd7;

	localparam logic [5:0] CMD0 = 6'd0;
	localparam logic [5:0] CMD8 = 6'd8;
	localparam logic [5:0] CMD16 = 6'd16;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] CMD41 = 6'd41;
	localparam logic [5:0] CMD55 = 6'd55;
	localparam logic [5:0] CMD58 = 6'd58;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_NOCARD = 4'd1;
	localparam logic [3:0] ST_NORESP = 4'd2;
	localparam logic [3:0] ST_UNUSABLE = 4'd3;
	localparam logic [3:0] ST_NOTREADY = 4'd4;
	localparam logic [3:0] ST_BUS = 4'd5;
	localparam logic [3:0] ST_READREJ = 4'd6;
	localparam logic [3:0] ST_NOTOKEN = 4'd7;
	localparam logic [3:0] ST_CRC = 4'd8;
	localparam logic [3:0] ST_WCMDREJ = 4'd9;
	localparam logic [3:0] ST_DATAREJ = 4'd10;
	localparam logic [3:0] ST_WBUSY = 4'd11;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [31:0] CMD8_ARG = 32'h0000_01AA;
	localparam logic [31:0] HCS_ARG = 32'h4000_0000;

	// CRC-16-CCITT over one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] x;
		x = c ^ {d, 8'h00};
		for (int i = 0; i < 8; i++) begin
			x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
		end
		return x;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

// ----- rtl/sdh_chan_if.sv -----
// ----------------------------------------------------------------------------
// sdh_chan_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface sdh_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sd_spi_host_engine_unit.sv -----
// ----------------------------------------------------------------------------
// sd_spi_host_engine_unit
// SD card SPI-mode host engine, one byte exchange per transfer.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | op, lba, rx_byte, write_byte, card_present, bus_error
//  out_ch  | out | action, tx_byte, select, rate, delay, read data, status
//  cfg_ch  | in  | register index, write data
//
// One item per cycle unless stalled: the engine state updates per item and
// the result lands in an output register. The input is accepted whenever
// the output register is empty or being drained in the same cycle.
// Reset clears all engine state; no clearing pass.
module sd_spi_host_engine_unit (
	input  logic clk,
	input  logic arst_n,
	sdh_chan_if.sink   in_ch,
	sdh_chan_if.source out_ch,
	sdh_chan_if.sink   cfg_ch
);
	import sdh_pkg::*;

	logic [7:0]  resp_poll, idle_retry;
	logic [11:0] opc_retry;
	logic [3:0]  illegal_lim;
	logic [19:0] token_poll, busy_poll;
	logic [1:0]  read_att;
	logic [5:0]  wake_bytes;
	logic        step, out_vld_q;
	sdh_out_t    res, res_q;

	sdh_cfg_regs u_cfg (
		.clk, .arst_n, .cfg(cfg_ch), .resp_poll, .idle_retry, .opc_retry, .illegal_lim,
		.token_poll, .busy_poll, .read_att, .wake_bytes
	);

	assign in_ch.ready = !out_vld_q || out_ch.ready;
	assign step = in_ch.valid && in_ch.ready;

	sdh_core u_core (
		.clk, .arst_n, .step, .in_d(in_ch.data), .resp_poll, .idle_retry, .opc_retry,
		.illegal_lim, .token_poll, .busy_poll, .read_att, .wake_bytes, .res
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_vld_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data = res_q;

`ifndef SYNTHESIS
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_vld_q)
		else $error("accepted transfer left no result");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && res_q.done_res) |-> (res_q.action == ACT_DONE))
		else $error("status final outside finished action");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken over a held result");
`endif
endmodule

// ----- rtl/sdh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sdh_cfg_regs
// Configuration register file; always ready.
// ----------------------------------------------------------------------------
module sdh_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	sdh_chan_if.sink cfg,
	output logic [7:0]  resp_poll,
	output logic [7:0]  idle_retry,
	output logic [11:0] opc_retry,
	output logic [3:0]  illegal_lim,
	output logic [19:0] token_poll,
	output logic [19:0] busy_poll,
	output logic [1:0]  read_att,
	output logic [5:0]  wake_bytes
);
	import sdh_pkg::*;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_poll <= 8'd10;
			idle_retry <= 8'd20;
			opc_retry <= 12'd1200;
			illegal_lim <= 4'd8;
			token_poll <= 20'd75000;
			busy_poll <= 20'd240000;
			read_att <= 2'd3;
			wake_bytes <= 6'd12;
		end else if (cfg.valid) begin
			unique case (cfg.data.idx)
				CFG_RESP_POLL: resp_poll <= cfg.data.data[7:0];
				CFG_IDLE_RETRY: idle_retry <= cfg.data.data[7:0];
				CFG_OPC_RETRY: opc_retry <= cfg.data.data[11:0];
				CFG_ILLEGAL: illegal_lim <= cfg.data.data[3:0];
				CFG_TOKEN_POLL: token_poll <= cfg.data.data;
				CFG_BUSY_POLL: busy_poll <= cfg.data.data;
				CFG_READ_ATT: read_att <= cfg.data.data[1:0];
				default: wake_bytes <= cfg.data.data[5:0];
			endcase
		end
	end
endmodule

// ----- rtl/sdh_core.sv -----
// ----------------------------------------------------------------------------
// sdh_core
// Engine state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module sdh_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  sdh_pkg::sdh_in_t  in_d,
	input  logic [7:0]  resp_poll,
	input  logic [7:0]  idle_retry,
	input  logic [11:0] opc_retry,
	input  logic [3:0]  illegal_lim,
	input  logic [19:0] token_poll,
	input  logic [19:0] busy_poll,
	input  logic [1:0]  read_att,
	input  logic [5:0]  wake_bytes,
	output sdh_pkg::sdh_out_t res
);
	import sdh_pkg::*;

	logic [4:0]  phase_q, ph;
	logic [19:0] bc_q, bc;
	logic [11:0] rc_q, rc;
	logic [3:0]  ill_q, ill;
	logic        rp_q, rp, init_q, ini, bm_q, bm, v2_q, v2;
	logic [1:0]  ra_q, ra;
	logic [7:0]  lr_q, lr;
	logic [31:0] tr_q, tr, ca_q, ca, lba_q, lb;
	logic [15:0] crc_q, crc, rcrc_q, rcrc, rt_q, rt, it_q, itot;
	logic [2:0]  res_q, rs;
	logic [5:0]  cmd_q, cmd;
	logic [3:0]  pend_q, pend;
	logic        wr_q, wr, bf_q, bf, slow_q, slow;
	logic [7:0]  txl_q, txl;

	// next-state logic; the model's nested calls become flag-driven sections
	always_comb begin
		logic [7:0]  rx, r1v, a8;
		logic        waiting, fin, req_end, begin_i, body, opc_ev, opc_st, c0s, ckdone;
		logic        r1done, tok_ev, cmd16r, r1chk, adv;
		logic [3:0]  st, fst;
		logic [31:0] arg;
		ph = phase_q; bc = bc_q; rc = rc_q; ill = ill_q; rp = rp_q; ini = init_q;
		bm = bm_q; v2 = v2_q; ra = ra_q; lr = lr_q; tr = tr_q; ca = ca_q; lb = lba_q;
		crc = crc_q; rcrc = rcrc_q; rt = rt_q; itot = it_q; rs = res_q; cmd = cmd_q;
		pend = pend_q; wr = wr_q; bf = bf_q; slow = slow_q; txl = txl_q;
		rx = in_d.bus_error ? 8'hFF : in_d.rx_byte;
		r1v = 8'hFF;
		waiting = (phase_q == P_PWR) || (phase_q == P_SETTLE) || (phase_q == P_GAP);
		fin = 1'b0; fst = ST_OK; req_end = 1'b0; st = ST_OK; begin_i = 1'b0;
		body = 1'b0; opc_ev = 1'b0; opc_st = 1'b0; c0s = 1'b0; ckdone = 1'b0;
		r1done = 1'b0; tok_ev = 1'b0; cmd16r = 1'b0; r1chk = 1'b0; adv = 1'b0;
		res = '0;

		if (phase_q == P_IDLE) begin
			if (in_d.op == OP_READ || in_d.op == OP_WRITE) begin
				wr = in_d.op[0]; lb = in_d.lba; ra = 2'd0;
				if (!wr && read_att == 2'd0) begin
					fin = 1'b1; fst = ST_READREJ;
				end else begin
					begin_i = 1'b1;
				end
			end
		end else if ((waiting && in_d.op == OP_WAIT) || (!waiting && in_d.op == OP_BYTE)) begin
			adv = 1'b1;
		end

		if (adv) begin
			if (phase_q != P_DESEL && phase_q != P_CLOCKS && in_d.bus_error) bf = 1'b1;
			case (phase_q)
				P_PWR: begin ph = P_DESEL; bc = '0; rs = R_CLOCKS; end
				P_SETTLE: c0s = 1'b1;
				P_GAP: begin
					rc = rc_q + 12'd1;
					if (rc >= {4'd0, idle_retry}) begin req_end = 1'b1; st = ST_NORESP; end
					else begin cmd = CMD0; ph = P_CMD; bc = '0; end
				end
				P_DESEL: begin
					bc = bc_q + 20'd1;
					if (bc >= 20'd2) begin
						case (rs)
							R_CLOCKS: begin
								ph = P_CLOCKS; bc = '0;
								if (wake_bytes == 6'd0) ckdone = 1'b1;
							end
							R_CMD0: if (lr_q == 8'h01) begin cmd = CMD8; ph = P_CMD; bc = '0; end
								else ph = P_GAP;
							R_CMD8: begin
								if (lr_q == 8'h01) begin
									if (tr_q[11:0] != 12'h1AA) begin
										req_end = 1'b1; st = ST_UNUSABLE;
									end else begin v2 = 1'b1; opc_st = 1'b1; end
								end else if (lr_q[2]) begin v2 = 1'b0; opc_st = 1'b1; end
								else begin req_end = 1'b1; st = ST_UNUSABLE; end
							end
							R_CMD55: begin
								if (bf_q) begin req_end = 1'b1; st = ST_BUS; end
								else if (lr_q != 8'h00 && lr_q != 8'h01) begin
									req_end = 1'b1; st = ST_UNUSABLE;
								end else begin cmd = CMD41; ph = P_CMD; bc = '0; end
							end
							R_CMD41: begin
								if (lr_q == 8'h00 || bf_q) opc_ev = 1'b1;
								else begin
									if (lr_q == 8'h05 && ill_q != 4'd15) ill = ill_q + 4'd1;
									if (lr_q == 8'h05 && (rp_q || ill >= illegal_lim))
										opc_ev = 1'b1;
									else begin
										rc = rc_q + 12'd1;
										if (rc >= opc_retry) opc_ev = 1'b1;
										else begin cmd = CMD55; ph = P_CMD; bc = '0; end
									end
								end
							end
							R_CMD58: begin
								if (lr_q != 8'h00) begin req_end = 1'b1; st = ST_UNUSABLE; end
								else begin bm = tr_q[30]; cmd16r = 1'b1; end
							end
							R_CMD16: if (lr_q != 8'h00) begin req_end = 1'b1; st = ST_UNUSABLE; end
								else begin ini = 1'b1; body = 1'b1; end
							default: begin req_end = 1'b1; st = pend_q; end
						endcase
					end
				end
				P_CLOCKS: begin
					if (in_d.bus_error) begin req_end = 1'b1; st = ST_BUS; end
					else begin
						bc = bc_q + 20'd1;
						if (bc >= {14'd0, wake_bytes}) ckdone = 1'b1;
					end
				end
				P_CMD: begin
					bc = bc_q + 20'd1;
					if (bc >= 20'd7) begin bc = '0; r1chk = 1'b1; end
				end
				P_R1: begin
					if (!rx[7]) begin r1done = 1'b1; r1v = rx; end
					else begin bc = bc_q + 20'd1; r1chk = 1'b1; end
				end
				P_TRAIL: begin
					tr = {tr_q[23:0], rx};
					bc = bc_q + 20'd1;
					if (bc >= 20'd4) begin
						ph = P_DESEL; bc = '0; rs = (cmd_q == CMD8) ? R_CMD8 : R_CMD58;
					end
				end
				P_TOKEN: begin
					lr = rx; bc = bc_q + 20'd1;
					if (rx != 8'hFF || bf || bc >= token_poll) tok_ev = 1'b1;
				end
				P_RDATA: begin
					res.read_data = rx; res.read_valid = 1'b1;
					crc = crc_byte(crc_q, rx);
					bc = bc_q + 20'd1;
					if (bc >= 20'd512) begin ph = P_RCRC; bc = '0; rcrc = '0; end
				end
				P_RCRC: begin
					rcrc = {rcrc_q[7:0], rx};
					bc = bc_q + 20'd1;
					if (bc >= 20'd2) begin
						ph = P_DESEL; bc = '0; rs = R_END;
						pend = bf ? ST_BUS : ((rcrc != crc_q) ? ST_CRC : ST_OK);
					end
				end
				P_WPRE: begin
					bc = bc_q + 20'd1;
					if (bc >= 20'd2) begin ph = P_WDATA; bc = '0; crc = '0; end
				end
				P_WDATA: begin
					crc = crc_byte(crc_q, txl_q);
					bc = bc_q + 20'd1;
					if (bc >= 20'd512) begin ph = P_WCRC; bc = '0; end
				end
				P_WCRC: begin
					bc = bc_q + 20'd1;
					if (bc >= 20'd2) begin
						if (bf) begin ph = P_DESEL; bc = '0; rs = R_END; pend = ST_BUS; end
						else ph = P_WRESP;
					end
				end
				P_WRESP: begin
					lr = rx;
					if ((rx & 8'h1F) != 8'h05) begin
						ph = P_DESEL; bc = '0; rs = R_END; pend = ST_DATAREJ;
					end else begin
						ph = P_BUSY; bc = '0;
						if (busy_poll == 20'd0) begin
							ph = P_DESEL; rs = R_END; pend = bf ? ST_BUS : ST_WBUSY;
						end
					end
				end
				P_BUSY: begin
					if (rx != 8'h00 || bf) begin
						ph = P_DESEL; bc = '0; rs = R_END; pend = bf ? ST_BUS : ST_OK;
					end else begin
						bc = bc_q + 20'd1;
						if (bc >= busy_poll) begin
							ph = P_DESEL; bc = '0; rs = R_END; pend = bf ? ST_BUS : ST_WBUSY;
						end
					end
				end
				default: ;
			endcase
		end

		// R1 poll check
		if (r1chk) begin
			if (bc >= {12'd0, resp_poll} || bf) begin r1done = 1'b1; r1v = 8'hFF; end
			else ph = P_R1;
		end
		// R1 handling
		if (r1done) begin
			lr = r1v;
			case (cmd)
				CMD0: begin ph = P_DESEL; bc = '0; rs = R_CMD0; end
				CMD8, CMD58: begin
					if (r1v == ((cmd == CMD8) ? 8'h01 : 8'h00)) begin
						ph = P_TRAIL; bc = '0; tr = '0;
					end else begin
						ph = P_DESEL; bc = '0; rs = (cmd == CMD8) ? R_CMD8 : R_CMD58;
					end
				end
				CMD55: begin ph = P_DESEL; bc = '0; rs = R_CMD55; end
				CMD41: begin ph = P_DESEL; bc = '0; rs = R_CMD41; end
				CMD16: begin ph = P_DESEL; bc = '0; rs = R_CMD16; end
				CMD17: begin
					if (r1v != 8'h00) begin ph = P_DESEL; bc = '0; rs = R_END; pend = ST_READREJ; end
					else begin
						ph = P_TOKEN; bc = '0; lr = 8'hFF;
						if (token_poll == 20'd0) tok_ev = 1'b1;
					end
				end
				default: begin
					if (r1v != 8'h00) begin ph = P_DESEL; bc = '0; rs = R_END; pend = ST_WCMDREJ; end
					else begin ph = P_WPRE; bc = '0; end
				end
			endcase
		end
		if (tok_ev) begin
			if (bf) begin ph = P_DESEL; bc = '0; rs = R_END; pend = ST_BUS; end
			else if (lr != 8'hFE) begin ph = P_DESEL; bc = '0; rs = R_END; pend = ST_NOTOKEN; end
			else begin ph = P_RDATA; bc = '0; crc = '0; end
		end
		// ACMD41 loop start and evaluation
		if (opc_st) begin
			ill = '0; rc = '0;
			if (opc_retry == 12'd0) opc_ev = 1'b1;
			else begin cmd = CMD55; ph = P_CMD; bc = '0; end
		end
		if (opc_ev) begin
			if (bf) begin req_end = 1'b1; st = ST_BUS; end
			else if (lr == 8'h00) begin
				if (v2) begin cmd = CMD58; ph = P_CMD; bc = '0; end
				else cmd16r = 1'b1;
			end else if (lr == 8'h05 && !rp && ill >= illegal_lim) begin
				rp = 1'b1; ph = P_DESEL; bc = '0; rs = R_CLOCKS;
			end else begin req_end = 1'b1; st = ST_NOTREADY; end
		end
		if (cmd16r) begin
			if (!bm) begin cmd = CMD16; ph = P_CMD; bc = '0; end
			else begin ini = 1'b1; body = 1'b1; end
		end
		if (ckdone) begin
			if (rp) ph = P_SETTLE; else c0s = 1'b1;
		end
		if (c0s) begin
			rc = '0;
			if (idle_retry == 8'd0) begin req_end = 1'b1; st = ST_NORESP; end
			else begin cmd = CMD0; ph = P_CMD; bc = '0; end
		end
		// request end, with read retry
		if (req_end) begin
			if (wr) begin
				if (st != ST_OK && st != ST_NOCARD) ini = 1'b0;
				fin = 1'b1; fst = st;
			end else if (st == ST_OK || st == ST_NOCARD || st == ST_NORESP ||
					st == ST_UNUSABLE || st == ST_NOTREADY) begin
				fin = 1'b1; fst = st;
			end else begin
				rt = sat_inc(rt_q); ini = 1'b0;
				if (ra != 2'd3) ra = ra + 2'd1;
				if (ra < read_att) begin_i = 1'b1;
				else begin fin = 1'b1; fst = st; end
			end
		end
		if (begin_i) begin
			if (!in_d.card_present) begin ini = 1'b0; fin = 1'b1; fst = ST_NOCARD; end
			else if (ini) body = 1'b1;
			else begin
				itot = sat_inc(rt == rt_q ? it_q : it_q);
				bm = 1'b0; bf = 1'b0; slow = 1'b1; rp = 1'b0; ph = P_PWR;
			end
		end
		if (body) begin
			bf = 1'b0;
			ca = bm ? lb : {lb[22:0], 9'd0};
			slow = 1'b0;
			cmd = wr ? CMD24 : CMD17; ph = P_CMD; bc = '0;
		end
		if (fin) ph = P_IDLE;

		// result
		res.action = ACT_XFER;
		res.tx_byte = 8'hFF;
		res.chip_select = 1'b1;
		arg = 32'd0;
		case (cmd)
			CMD8: arg = CMD8_ARG;
			CMD41: arg = v2 ? HCS_ARG : 32'd0;
			CMD16: arg = 32'd512;
			CMD17, CMD24: arg = ca;
			default: arg = 32'd0;
		endcase
		a8 = 8'hFF;
		case (bc[2:0])
			3'd0: a8 = 8'hFF;
			3'd1: a8 = {2'b01, cmd};
			3'd2: a8 = arg[31:24];
			3'd3: a8 = arg[23:16];
			3'd4: a8 = arg[15:8];
			3'd5: a8 = arg[7:0];
			default: a8 = (cmd == CMD0) ? 8'h95 : ((cmd == CMD8) ? 8'h87 : 8'h01);
		endcase
		case (ph)
			P_IDLE: begin res.action = ACT_DONE; res.chip_select = 1'b0; end
			P_PWR, P_SETTLE: begin
				res.action = ACT_WAIT; res.chip_select = 1'b0; res.delay_ms = 4'd10;
			end
			P_GAP: begin res.action = ACT_WAIT; res.chip_select = 1'b0; res.delay_ms = 4'd2; end
			P_DESEL, P_CLOCKS: res.chip_select = 1'b0;
			P_CMD: res.tx_byte = a8;
			P_WPRE: res.tx_byte = (bc == 20'd0) ? 8'hFF : 8'hFE;
			P_WDATA: begin txl = in_d.write_byte; res.tx_byte = txl; res.write_taken = 1'b1; end
			P_WCRC: res.tx_byte = (bc == 20'd0) ? crc[15:8] : crc[7:0];
			default: ;
		endcase
		if (res.action != ACT_XFER) res.tx_byte = 8'hFF;
		res.slow_clock = slow;
		res.status = fin ? fst : ST_OK;
		res.done_res = fin;
		res.read_retry_count = rt;
		res.reinit_count = itot;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; bc_q <= '0; rc_q <= '0; ill_q <= '0; rp_q <= 1'b0;
			init_q <= 1'b0; bm_q <= 1'b0; v2_q <= 1'b0; ra_q <= '0; lr_q <= 8'hFF;
			tr_q <= '0; ca_q <= '0; lba_q <= '0; crc_q <= '0; rcrc_q <= '0;
			rt_q <= '0; it_q <= '0; res_q <= R_CLOCKS; cmd_q <= CMD0; pend_q <= ST_OK;
			wr_q <= 1'b0; bf_q <= 1'b0; slow_q <= 1'b1; txl_q <= '0;
		end else if (step) begin
			phase_q <= ph; bc_q <= bc; rc_q <= rc; ill_q <= ill; rp_q <= rp;
			init_q <= ini; bm_q <= bm; v2_q <= v2; ra_q <= ra; lr_q <= lr;
			tr_q <= tr; ca_q <= ca; lba_q <= lb; crc_q <= crc; rcrc_q <= rcrc;
			rt_q <= rt; it_q <= itot; res_q <= rs; cmd_q <= cmd; pend_q <= pend;
			wr_q <= wr; bf_q <= bf; slow_q <= slow; txl_q <= txl;
		end
	end
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SD SPI host engine. It models the engine state
// in the bench, plays a card that answers commands, tokens, CRCs and busy,
// mixes in noise, and compares every result transfer with the expected one.
// ----------------------------------------------------------------------------
module tb;
	import sdh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BLOCK_LEN = 512;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned TOTAL_ITEMS = 1750;

	logic clk;
	logic arst_n;

	sdh_chan_if #(.T(sdh_in_t))  in_ch ();
	sdh_chan_if #(.T(sdh_out_t)) out_ch ();
	sdh_chan_if #(.T(sdh_cfg_t)) cfg_ch ();

	sd_spi_host_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// clock, period 8 ns
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	sdh_out_t    expected_results[$];
	int unsigned errors;
	int unsigned sent_items;
	int unsigned stall_cycles;
	bit          quiet;

	// engine model state
	logic [4:0]  ph;
	int unsigned bcnt, rcnt, illcnt, ratt;
	bit          recov, inited, blk, v2, fin, wr, busf, slow, present;
	logic [7:0]  lastr, txl, step_rd;
	bit          step_rv;
	logic [31:0] trail, caddr, rlba;
	logic [15:0] crc_run, crc_rx, tot_retry, tot_reinit;
	logic [2:0]  resume;
	logic [5:0]  ccmd;
	logic [3:0]  pstat, fstat;
	int unsigned lim_resp, lim_idle, lim_opc, lim_ill, lim_tok, lim_busy, lim_att, lim_wake;

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] x;
		x = c ^ {d, 8'h00};
		for (int i = 0; i < 8; i++)
			x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
		return x;
	endfunction

	function automatic logic [15:0] sat16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] cmd_argument(input logic [5:0] c);
		case (c)
			CMD8:         return CMD8_ARG;
			CMD41:        return v2 ? HCS_ARG : 32'd0;
			CMD16:        return BLOCK_LEN;
			CMD17, CMD24: return caddr;
			default:      return 32'd0;
		endcase
	endfunction

	function automatic void model_reset();
		lim_resp = 10; lim_idle = 20; lim_opc = 1200; lim_ill = 8;
		lim_tok = 75000; lim_busy = 240000; lim_att = 3; lim_wake = 12;
		ph = P_IDLE; bcnt = 0; rcnt = 0; illcnt = 0; recov = 0; ratt = 0;
		inited = 0; blk = 0; v2 = 0; lastr = 8'hFF; trail = 0; crc_run = 0;
		crc_rx = 0; caddr = 0; tot_retry = 0; tot_reinit = 0; resume = R_CLOCKS;
		ccmd = CMD0; pstat = ST_OK; fstat = ST_OK; fin = 0; rlba = 0; wr = 0;
		busf = 0; slow = 1; txl = 0; present = 0;
	endfunction

	function automatic void model_config(input logic [2:0] idx, input logic [19:0] v);
		case (idx)
			CFG_RESP_POLL:  lim_resp = v[7:0];
			CFG_IDLE_RETRY: lim_idle = v[7:0];
			CFG_OPC_RETRY:  lim_opc = v[11:0];
			CFG_ILLEGAL:    lim_ill = v[3:0];
			CFG_TOKEN_POLL: lim_tok = v;
			CFG_BUSY_POLL:  lim_busy = v;
			CFG_READ_ATT:   lim_att = v[1:0];
			default:        lim_wake = v[5:0];
		endcase
	endfunction

	function automatic void finish_req(input logic [3:0] st);
		ph = P_IDLE; fstat = st; fin = 1;
	endfunction

	function automatic void go_desel(input logic [2:0] r);
		ph = P_DESEL; bcnt = 0; resume = r;
	endfunction

	function automatic void end_desel(input logic [3:0] st);
		pstat = st; go_desel(R_END);
	endfunction

	function automatic void start_cmd(input logic [5:0] c);
		ccmd = c; ph = P_CMD; bcnt = 0;
	endfunction

	function automatic void body_start();
		busf = 0;
		caddr = blk ? rlba : {rlba[22:0], 9'd0};
		slow = 0;
		start_cmd(wr ? CMD24 : CMD17);
	endfunction

	function automatic void init_ok();
		inited = 1; body_start();
	endfunction

	function automatic void cmd16_or_ready();
		if (!blk) start_cmd(CMD16); else init_ok();
	endfunction

	function automatic void cmd0_loop_start();
		rcnt = 0;
		if (lim_idle == 0) request_end(ST_NORESP); else start_cmd(CMD0);
	endfunction

	function automatic void clocks_done();
		if (recov) ph = P_SETTLE; else cmd0_loop_start();
	endfunction

	function automatic void clocks_start();
		ph = P_CLOCKS; bcnt = 0;
		if (lim_wake == 0) clocks_done();
	endfunction

	function automatic void opc_eval();
		if (busf) begin
			request_end(ST_BUS);
		end else if (lastr == 8'h00) begin
			if (v2) start_cmd(CMD58); else cmd16_or_ready();
		end else if (lastr == 8'h05 && !recov && illcnt >= lim_ill) begin
			recov = 1;
			go_desel(R_CLOCKS);
		end else begin
			request_end(ST_NOTREADY);
		end
	endfunction

	function automatic void opc_start();
		illcnt = 0; rcnt = 0;
		if (lim_opc == 0) opc_eval(); else start_cmd(CMD55);
	endfunction

	function automatic void begin_inner();
		if (!present) begin
			inited = 0;
			request_end(ST_NOCARD);
		end else if (inited) begin
			body_start();
		end else begin
			tot_reinit = sat16(tot_reinit);
			blk = 0; busf = 0; slow = 1; recov = 0;
			ph = P_PWR;
		end
	endfunction

	// reads retry on bus, token, CRC and rejection failures
	function automatic void request_end(input logic [3:0] st);
		if (wr) begin
			if (st != ST_OK && st != ST_NOCARD) inited = 0;
			finish_req(st);
		end else if (st == ST_OK || st == ST_NOCARD || st == ST_NORESP ||
				st == ST_UNUSABLE || st == ST_NOTREADY) begin
			finish_req(st);
		end else begin
			tot_retry = sat16(tot_retry);
			inited = 0;
			if (ratt < 3) ratt++;
			if (ratt < lim_att) begin_inner(); else finish_req(st);
		end
	endfunction

	function automatic void after_desel();
		logic [7:0] r;
		r = lastr;
		case (resume)
			R_CLOCKS: clocks_start();
			R_CMD0: begin
				if (r == 8'h01) start_cmd(CMD8); else ph = P_GAP;
			end
			R_CMD8: begin
				if (r == 8'h01) begin
					if (trail[11:0] != 12'h1AA) begin
						request_end(ST_UNUSABLE);
					end else begin
						v2 = 1;
						opc_start();
					end
				end else if (r[2]) begin
					v2 = 0;
					opc_start();
				end else begin
					request_end(ST_UNUSABLE);
				end
			end
			R_CMD55: begin
				if (busf) request_end(ST_BUS);
				else if (r != 8'h00 && r != 8'h01) request_end(ST_UNUSABLE);
				else start_cmd(CMD41);
			end
			R_CMD41: begin
				if (r == 8'h00 || busf) begin
					opc_eval();
				end else begin
					if (r == 8'h05 && illcnt < 15) illcnt++;
					if (r == 8'h05 && (recov || illcnt >= lim_ill)) begin
						opc_eval();
					end else begin
						rcnt++;
						if (rcnt >= lim_opc) opc_eval(); else start_cmd(CMD55);
					end
				end
			end
			R_CMD58: begin
				if (r != 8'h00) begin
					request_end(ST_UNUSABLE);
				end else begin
					blk = trail[30];
					cmd16_or_ready();
				end
			end
			R_CMD16: begin
				if (r != 8'h00) request_end(ST_UNUSABLE); else init_ok();
			end
			default: request_end(pstat);
		endcase
	endfunction

	function automatic void token_eval();
		if (busf) end_desel(ST_BUS);
		else if (lastr != 8'hFE) end_desel(ST_NOTOKEN);
		else begin
			ph = P_RDATA; bcnt = 0; crc_run = 0;
		end
	endfunction

	function automatic void busy_eval(input bit timed_out);
		if (busf) end_desel(ST_BUS);
		else end_desel(timed_out ? ST_WBUSY : ST_OK);
	endfunction

	function automatic void r1_done(input logic [7:0] r1);
		lastr = r1;
		case (ccmd)
			CMD0: go_desel(R_CMD0);
			CMD8, CMD58: begin
				if (r1 == ((ccmd == CMD8) ? 8'h01 : 8'h00)) begin
					ph = P_TRAIL; bcnt = 0; trail = 0;
				end else begin
					go_desel((ccmd == CMD8) ? R_CMD8 : R_CMD58);
				end
			end
			CMD55: go_desel(R_CMD55);
			CMD41: go_desel(R_CMD41);
			CMD16: go_desel(R_CMD16);
			CMD17: begin
				if (r1 != 8'h00) begin
					end_desel(ST_READREJ);
				end else begin
					ph = P_TOKEN; bcnt = 0; lastr = 8'hFF;
					if (lim_tok == 0) token_eval();
				end
			end
			default: begin
				if (r1 != 8'h00) end_desel(ST_WCMDREJ);
				else begin
					ph = P_WPRE; bcnt = 0;
				end
			end
		endcase
	endfunction

	function automatic void r1_poll_check();
		if (bcnt >= lim_resp || busf) r1_done(8'hFF); else ph = P_R1;
	endfunction

	// one byte or wait step of the engine
	function automatic void advance(input logic [7:0] rx, input bit err);
		if (ph != P_DESEL && ph != P_CLOCKS && err) busf = 1;
		case (ph)
			P_PWR:    go_desel(R_CLOCKS);
			P_SETTLE: cmd0_loop_start();
			P_GAP: begin
				rcnt++;
				if (rcnt >= lim_idle) request_end(ST_NORESP); else start_cmd(CMD0);
			end
			P_DESEL: begin
				bcnt++;
				if (bcnt >= 2) after_desel();
			end
			P_CLOCKS: begin
				if (err) begin
					request_end(ST_BUS);
				end else begin
					bcnt++;
					if (bcnt >= lim_wake) clocks_done();
				end
			end
			P_CMD: begin
				bcnt++;
				if (bcnt >= 7) begin
					bcnt = 0;
					r1_poll_check();
				end
			end
			P_R1: begin
				if (!rx[7]) begin
					r1_done(rx);
				end else begin
					bcnt++;
					r1_poll_check();
				end
			end
			P_TRAIL: begin
				trail = {trail[23:0], rx};
				bcnt++;
				if (bcnt >= 4) go_desel((ccmd == CMD8) ? R_CMD8 : R_CMD58);
			end
			P_TOKEN: begin
				lastr = rx;
				bcnt++;
				if (rx != 8'hFF || busf || bcnt >= lim_tok) token_eval();
			end
			P_RDATA: begin
				step_rd = rx; step_rv = 1;
				crc_run = crc16_step(crc_run, rx);
				bcnt++;
				if (bcnt >= BLOCK_LEN) begin
					ph = P_RCRC; bcnt = 0; crc_rx = 0;
				end
			end
			P_RCRC: begin
				crc_rx = {crc_rx[7:0], rx};
				bcnt++;
				if (bcnt >= 2) begin
					if (busf) end_desel(ST_BUS);
					else end_desel((crc_rx != crc_run) ? ST_CRC : ST_OK);
				end
			end
			P_WPRE: begin
				bcnt++;
				if (bcnt >= 2) begin
					ph = P_WDATA; bcnt = 0; crc_run = 0;
				end
			end
			P_WDATA: begin
				crc_run = crc16_step(crc_run, txl);
				bcnt++;
				if (bcnt >= BLOCK_LEN) begin
					ph = P_WCRC; bcnt = 0;
				end
			end
			P_WCRC: begin
				bcnt++;
				if (bcnt >= 2) begin
					if (busf) end_desel(ST_BUS); else ph = P_WRESP;
				end
			end
			P_WRESP: begin
				lastr = rx;
				if (rx[4:0] != 5'h05) begin
					end_desel(ST_DATAREJ);
				end else begin
					ph = P_BUSY; bcnt = 0;
					if (lim_busy == 0) busy_eval(1'b1);
				end
			end
			P_BUSY: begin
				if (rx != 8'h00 || busf) begin
					busy_eval(1'b0);
				end else begin
					bcnt++;
					if (bcnt >= lim_busy) busy_eval(1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic bit is_waiting();
		return ph == P_PWR || ph == P_SETTLE || ph == P_GAP;
	endfunction

	function automatic sdh_out_t predict_engine_step(input sdh_in_t it);
		sdh_out_t    r;
		logic [31:0] arg;
		logic [7:0]  rx;
		rx = it.bus_error ? 8'hFF : it.rx_byte;
		present = it.card_present;
		fin = 0; step_rd = 0; step_rv = 0;
		if (ph == P_IDLE) begin
			if (it.op == OP_READ || it.op == OP_WRITE) begin
				wr = (it.op == OP_WRITE);
				rlba = it.lba;
				ratt = 0;
				if (!wr && lim_att == 0) finish_req(ST_READREJ); else begin_inner();
			end
		end else if ((is_waiting() && it.op == OP_WAIT) || (!is_waiting() && it.op == OP_BYTE)) begin
			advance(rx, it.bus_error);
		end
		r = '0;
		r.action = ACT_XFER;
		r.tx_byte = 8'hFF;
		r.chip_select = 1'b1;
		arg = cmd_argument(ccmd);
		case (ph)
			P_IDLE: begin
				r.action = ACT_DONE; r.chip_select = 0;
			end
			P_PWR, P_SETTLE: begin
				r.action = ACT_WAIT; r.chip_select = 0; r.delay_ms = 4'd10;
			end
			P_GAP: begin
				r.action = ACT_WAIT; r.chip_select = 0; r.delay_ms = 4'd2;
			end
			P_DESEL, P_CLOCKS: r.chip_select = 0;
			P_CMD: begin
				case (bcnt)
					0: r.tx_byte = 8'hFF;
					1: r.tx_byte = {2'b01, ccmd};
					2: r.tx_byte = arg[31:24];
					3: r.tx_byte = arg[23:16];
					4: r.tx_byte = arg[15:8];
					5: r.tx_byte = arg[7:0];
					default: r.tx_byte = (ccmd == CMD0) ? 8'h95 : (ccmd == CMD8) ? 8'h87 : 8'h01;
				endcase
			end
			P_WPRE: r.tx_byte = (bcnt == 0) ? 8'hFF : 8'hFE;
			P_WDATA: begin
				txl = it.write_byte; r.tx_byte = txl; r.write_taken = 1;
			end
			P_WCRC: r.tx_byte = (bcnt == 0) ? crc_run[15:8] : crc_run[7:0];
			default: ;
		endcase
		r.slow_clock = slow;
		r.read_data = step_rd;
		r.read_valid = step_rv;
		r.status = fin ? fstat : ST_OK;
		r.done_res = fin;
		r.read_retry_count = tot_retry;
		r.reinit_count = tot_reinit;
		return r;
	endfunction

	// card side: answer the byte the engine is about to clock
	function automatic logic [7:0] card_reply();
		int unsigned p;
		p = $urandom_range(0, 99);
		case (ph)
			P_R1: begin
				if (p < 25) return 8'hFF;
				case (ccmd)
					CMD8:  return (p < 80) ? 8'h01 : 8'h05;
					CMD0, CMD55: return 8'h01;
					CMD41: return (p < 60) ? 8'h00 : (p < 78) ? 8'h05 : 8'h01;
					default: return 8'h00;
				endcase
			end
			P_TRAIL: begin
				if (ccmd == CMD8) begin
					case (bcnt)
						0, 1: return 8'h00;
						2: return 8'h01;
						default: return 8'hAA;
					endcase
				end
				return (bcnt == 0) ? (p[0] ? 8'hC0 : 8'h80) : 8'hFF;
			end
			P_TOKEN: return (p < 30) ? 8'hFF : 8'hFE;
			P_RCRC: return (bcnt == 0) ? crc_run[15:8] : crc_run[7:0];
			P_WRESP: return {3'($urandom), 5'h05};
			P_BUSY: return (p < 40) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	// one input transfer, prediction on acceptance
	task automatic send_item(input sdh_in_t it);
		if (!quiet && $urandom_range(0, 99) < 37) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 37);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		expected_results.push_back(predict_engine_step(it));
		sent_items++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned v);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{idx: idx, data: 20'(v)};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		model_config(idx, 20'(v));
	endtask

	task automatic write_all(input int unsigned v0, v1, v2r, v3, v4, v5, v6, v7);
		write_reg(CFG_RESP_POLL, v0);
		write_reg(CFG_IDLE_RETRY, v1);
		write_reg(CFG_OPC_RETRY, v2r);
		write_reg(CFG_ILLEGAL, v3);
		write_reg(CFG_TOKEN_POLL, v4);
		write_reg(CFG_BUSY_POLL, v5);
		write_reg(CFG_READ_ATT, v6);
		write_reg(CFG_WAKE, v7);
	endtask

	// start a request and play the card until the engine reports done
	task automatic run_request(input logic [1:0] op, input logic [31:0] lba,
			input int unsigned noise, input bit seated);
		sdh_in_t it;
		it = '{op: op, lba: lba, rx_byte: 8'($urandom), write_byte: 8'($urandom),
			card_present: seated, bus_error: 1'b0};
		send_item(it);
		while (ph != P_IDLE) begin
			if ($urandom_range(0, 99) < noise) begin
				it.op = 2'($urandom);
				it.rx_byte = 8'($urandom);
				it.card_present = $urandom_range(0, 3) != 0;
				it.bus_error = 1'($urandom_range(0, 1));
			end else begin
				it.op = is_waiting() ? OP_WAIT : OP_BYTE;
				it.rx_byte = card_reply();
				it.card_present = 1'b1;
				it.bus_error = 1'b0;
			end
			it.lba = $urandom;
			it.write_byte = 8'($urandom);
			send_item(it);
		end
	endtask

	task automatic test_idle_ops();
		sdh_in_t it;
		it = '{op: OP_BYTE, lba: '1, rx_byte: 8'h00, write_byte: 8'hFF,
			card_present: 1'b1, bus_error: 1'b1};
		send_item(it);
		it.op = OP_WAIT;
		send_item(it);
		run_request(OP_READ, 32'h0, 0, 1'b0);
		run_request(OP_WRITE, 32'hFFFF_FFFF, 0, 1'b0);
	endtask

	task automatic test_default_transfers();
		run_request(OP_READ, 32'hFFFF_FFFF, 0, 1'b1);
	endtask

	task automatic test_low_limits();
		write_all(1, 1, 1, 1, 1, 1, 1, 10);
		run_request(OP_WRITE, 32'h0000_0001, 30, 1'b1);
	endtask

	task automatic test_zero_limits();
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		run_request(OP_READ, 32'h5, 0, 1'b1);
		write_reg(CFG_READ_ATT, 1);
		run_request(OP_READ, 32'h6, 0, 1'b1);
		run_request(OP_WRITE, 32'h7, 0, 1'b1);
	endtask

	task automatic test_high_limits();
		write_all(255, 255, 4095, 15, 20'hFFFFF, 20'hFFFFF, 3, 63);
		run_request(OP_READ, 32'h8000_0000, 0, 1'b1);
	endtask

	task automatic test_random_requests();
		int unsigned noise;
		write_all(10, 20, 1200, 8, 75000, 240000, 3, 12);
		while (sent_items < TOTAL_ITEMS) begin
			if ($urandom_range(0, 99) < 30) begin
				case ($urandom_range(0, 7))
					0: write_reg(CFG_RESP_POLL, $urandom_range(1, 255));
					1: write_reg(CFG_IDLE_RETRY, $urandom_range(1, 255));
					2: write_reg(CFG_OPC_RETRY, $urandom_range(1, 4095));
					3: write_reg(CFG_ILLEGAL, $urandom_range(1, 15));
					4: write_reg(CFG_TOKEN_POLL, $urandom_range(1, 20'hFFFFF));
					5: write_reg(CFG_BUSY_POLL, $urandom_range(1, 20'hFFFFF));
					6: write_reg(CFG_READ_ATT, $urandom_range(1, 3));
					default: write_reg(CFG_WAKE, $urandom_range(10, 63));
				endcase
			end
			quiet = ($urandom_range(0, 5) == 0);
			noise = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
			run_request(2'($urandom_range(0, 1)), $urandom, noise, $urandom_range(0, 19) != 0);
		end
		quiet = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		sdh_out_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_results.size() == 0) begin
				report("unexpected result", got.action, 0);
			end else begin
				want = expected_results.pop_front();
				if (got.action !== want.action) report("action", got.action, want.action);
				if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
				if (got.chip_select !== want.chip_select)
					report("chip_select", got.chip_select, want.chip_select);
				if (got.slow_clock !== want.slow_clock)
					report("slow_clock", got.slow_clock, want.slow_clock);
				if (got.delay_ms !== want.delay_ms) report("delay_ms", got.delay_ms, want.delay_ms);
				if (got.read_data !== want.read_data)
					report("read_data", got.read_data, want.read_data);
				if (got.read_valid !== want.read_valid)
					report("read_valid", got.read_valid, want.read_valid);
				if (got.write_taken !== want.write_taken)
					report("write_taken", got.write_taken, want.write_taken);
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
				if (got.read_retry_count !== want.read_retry_count)
					report("read_retry_count", got.read_retry_count, want.read_retry_count);
				if (got.reinit_count !== want.reinit_count)
					report("reinit_count", got.reinit_count, want.reinit_count);
			end
		end
	end

	// result side stalls
	always @(posedge clk) out_ch.ready <= quiet || ($urandom_range(0, 99) >= 37);

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("sd_spi_host_engine_unit: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		sent_items = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ops();
		test_default_transfers();
		test_low_limits();
		test_zero_limits();
		test_high_limits();
		test_random_requests();

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("sd_spi_host_engine_unit: match");
		end else begin
			$display("sd_spi_host_engine_unit: mismatch");
		end
		$finish;
	end

endmodule
